FILE: rtl/wl512_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the well512 random generator
// no dependencies; used by the generator, pool and divider modules

package wl512_pkg;

    localparam int WORD_W     = 32;
    localparam int POOL_DEPTH = 16;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int BOUND_W    = 31;
    localparam int DIV_CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [POOL_AW-1:0] pool_addr_t;

    // seed expansion, tempering and pool address constants
    localparam word_t      EXPAND_MULT = 32'd1812433253;
    localparam word_t      TEMPER_MASK = 32'hDA442D24;
    localparam pool_addr_t TAP_A       = 4'd13;
    localparam pool_addr_t TAP_B       = 4'd9;
    localparam pool_addr_t STEP_BACK   = 4'd15;
    localparam pool_addr_t LAST_ADDR   = pool_addr_t'(POOL_DEPTH - 1);

    // draw operation codes
    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    // write port of the pool memory
    typedef struct packed {
        logic       en;
        pool_addr_t addr;
        word_t      data;
    } pool_wr_t;

endpackage

FILE: rtl/well512_random_generator.sv
`timescale 1ns / 1ps
// A raw draw steps through pool read states R0 to R4 to the output register; a bounded
// draw adds the one-bit-per-cycle remainder unit (32 steps plus handoff).
// The first draw after reset or a seed write first fills the pool, one word at a time
// through states EXP_MUL and EXP_ADD and a single 32x32 multiplier.
// One item at a time: no new input is taken until the result is loaded for output.
// Reset (synchronous, active low) clears the seed to 0 and marks the pool for refill.

module well512_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [30:0] s_bound,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED0,
        ST_EXP_MUL,
        ST_EXP_ADD,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t                state_reg;
    wl512_pkg::word_t      seed_reg;
    logic                  pending_reg;
    wl512_pkg::pool_addr_t pos_reg;
    wl512_pkg::pool_addr_t cnt_reg;
    logic                  op_reg;
    logic [wl512_pkg::BOUND_W-1:0] bound_reg;
    wl512_pkg::word_t      p_reg;
    wl512_pkg::word_t      mul_reg;
    wl512_pkg::word_t      a_reg;
    wl512_pkg::word_t      b_reg;
    wl512_pkg::word_t      c_reg;
    wl512_pkg::word_t      word_reg;
    logic                  m_valid_reg;
    wl512_pkg::word_t      m_value_reg;

    wl512_pkg::pool_wr_t   pool_wr;
    wl512_pkg::pool_addr_t rd_addr;
    wl512_pkg::word_t      rd_data;
    wl512_pkg::word_t      mul_in;
    wl512_pkg::word_t      mul_out;
    wl512_pkg::word_t      exp_word;
    wl512_pkg::word_t      b_new;
    wl512_pkg::word_t      c_new;
    wl512_pkg::word_t      a_new;
    wl512_pkg::word_t      d_val;
    wl512_pkg::word_t      z_new;
    wl512_pkg::word_t      div_rem;
    logic                  div_start;
    logic                  div_done;
    logic                  s_xfer;
    logic                  out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // pool memory
    wl512_pool u_pool (
        .aclk    (aclk),
        .wr      (pool_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // remainder unit for bounded draws
    assign div_start = (state_reg == ST_DIV_GO);

    wl512_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (word_reg),
        .divisor   ({1'b0, bound_reg} + 1'b1),
        .done      (div_done),
        .remainder (div_rem)
    );

    // seed expansion datapath, multiplier registered before the add
    assign mul_in   = p_reg ^ (p_reg >> 30);
    assign mul_out  = wl512_pkg::EXPAND_MULT * mul_in;
    assign exp_word = mul_reg + wl512_pkg::word_t'(cnt_reg);

    // draw datapath, terms formed from the registered pool reads
    assign b_new = a_reg ^ rd_data ^ (a_reg << 16) ^ (rd_data << 15);
    assign c_new = rd_data ^ (rd_data >> 11);
    assign a_new = b_reg ^ c_new;
    assign d_val = a_reg ^ ((a_reg << 5) & wl512_pkg::TEMPER_MASK);
    assign z_new = rd_data ^ b_reg ^ d_val ^ (rd_data << 2) ^ (b_reg << 18)
                 ^ (c_reg << 28);

    // pool read address and write port per state
    always_comb begin
        rd_addr      = pos_reg;
        pool_wr.en   = 1'b0;
        pool_wr.addr = pos_reg;
        pool_wr.data = a_new;
        unique case (state_reg)
            ST_SEED0: begin
                pool_wr.en   = 1'b1;
                pool_wr.addr = '0;
                pool_wr.data = seed_reg;
            end
            ST_EXP_ADD: begin
                pool_wr.en   = 1'b1;
                pool_wr.addr = cnt_reg;
                pool_wr.data = exp_word;
            end
            ST_R1: rd_addr = pos_reg + wl512_pkg::TAP_A;
            ST_R2: rd_addr = pos_reg + wl512_pkg::TAP_B;
            ST_R3: begin
                rd_addr    = pos_reg + wl512_pkg::STEP_BACK;
                pool_wr.en = 1'b1;
            end
            ST_R4: begin
                pool_wr.en   = 1'b1;
                pool_wr.addr = pos_reg + wl512_pkg::STEP_BACK;
                pool_wr.data = z_new;
            end
            default: rd_addr = pos_reg;
        endcase
    end

    // sequencer, generator state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= '0;
            pending_reg <= 1'b1;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // result leaves on its output transfer unless a new one is loaded
            if (m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                seed_reg    <= cfg_wdata;
                pending_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        op_reg    <= s_op;
                        bound_reg <= s_bound;
                        state_reg <= pending_reg ? ST_SEED0 : ST_R0;
                    end
                end
                ST_SEED0: begin
                    p_reg       <= seed_reg;
                    cnt_reg     <= wl512_pkg::pool_addr_t'(1);
                    pos_reg     <= '0;
                    // a seed written right now keeps the refill pending
                    if (!cfg_we) begin
                        pending_reg <= 1'b0;
                    end
                    state_reg   <= ST_EXP_MUL;
                end
                ST_EXP_MUL: begin
                    mul_reg   <= mul_out;
                    state_reg <= ST_EXP_ADD;
                end
                ST_EXP_ADD: begin
                    p_reg   <= exp_word;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == wl512_pkg::LAST_ADDR) begin
                        state_reg <= ST_R0;
                    end else begin
                        state_reg <= ST_EXP_MUL;
                    end
                end
                ST_R0: state_reg <= ST_R1;
                ST_R1: begin
                    a_reg     <= rd_data;
                    state_reg <= ST_R2;
                end
                ST_R2: begin
                    b_reg     <= b_new;
                    state_reg <= ST_R3;
                end
                ST_R3: begin
                    c_reg     <= c_new;
                    a_reg     <= a_new;
                    state_reg <= ST_R4;
                end
                ST_R4: begin
                    word_reg  <= z_new;
                    pos_reg   <= pos_reg + wl512_pkg::STEP_BACK;
                    state_reg <= (op_reg == wl512_pkg::OP_BOUNDED) ? ST_DIV_GO : ST_OUT;
                end
                ST_DIV_GO: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        word_reg  <= div_rem;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= word_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule

FILE: rtl/wl512_pool.sv
`timescale 1ns / 1ps
// 16 x 32 pool memory, one write and one registered read per cycle
// depends on wl512_pkg

module wl512_pool (
    input  logic                  aclk,
    input  wl512_pkg::pool_wr_t   wr,
    input  wl512_pkg::pool_addr_t rd_addr,
    output wl512_pkg::word_t      rd_data
);

    wl512_pkg::word_t mem [wl512_pkg::POOL_DEPTH];
    wl512_pkg::word_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/wl512_divider.sv
`timescale 1ns / 1ps
// radix-2 restoring remainder unit, one quotient bit per cycle
// depends on wl512_pkg

module wl512_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  wl512_pkg::word_t dividend,
    input  wl512_pkg::word_t divisor,
    output logic             done,
    output wl512_pkg::word_t remainder
);

    localparam logic [wl512_pkg::DIV_CNT_W-1:0] LAST_STEP =
        wl512_pkg::DIV_CNT_W'(wl512_pkg::WORD_W - 1);

    wl512_pkg::word_t rem_reg;
    wl512_pkg::word_t dvd_reg;
    wl512_pkg::word_t dv_reg;
    logic [wl512_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;

    wl512_pkg::word_t trial;
    wl512_pkg::word_t rem_next;

    // shift in the next dividend bit and subtract when it fits
    // divisor is at most 2^31, so the remainder's top bit is always clear
    always_comb begin
        trial = {rem_reg[wl512_pkg::WORD_W-2:0], dvd_reg[wl512_pkg::WORD_W-1]};
        if (trial >= dv_reg) begin
            rem_next = trial - dv_reg;
        end else begin
            rem_next = trial;
        end
    end

    // step counter and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dv_reg   <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[wl512_pkg::WORD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/wl512_checker.sv
`timescale 1ns / 1ps
// port-level checks for the well512 random generator
// bound to well512_random_generator at the end of this file

module wl512_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value
);

    // no result is shown right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // one draw at a time: ready drops after each input transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after input transfer");

    // a result never appears in the cycle right after an input transfer
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("stalled result changed");

endmodule

bind well512_random_generator wl512_checker u_wl512_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);
